/* design/aba_pkg.sv */
// Package for the aligned bump allocator: field widths, status codes,
// register indexes and sequencer state encoding. No dependencies.
`default_nettype none
package aba_pkg;

  localparam int OFFSET_BITS = 40;

  localparam int SIZE_W   = 40;
  localparam int ALIGN_W  = 16;
  localparam int GEN_W    = 32;
  localparam int CAP_W    = 40;
  localparam int USED_W   = 40;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 40;
  localparam int CFG_IDX_W = 1;

  // sums carry two extra bits so both adds can be range-checked
  localparam int SUM_W = USED_W + 2;
  localparam logic [SUM_W-1:0] OFFSET_MAX = (SUM_W'(1) << OFFSET_BITS) - SUM_W'(1);

  localparam int DIV_CNT_W = $clog2(USED_W);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_ALIGN = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_CAPACITY  = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_ADD  = 5'b00100,
    S_CHK  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

/* design/aba_if.sv */
// Valid/ready channel interfaces for allocation requests and results.
// Depends on aba_pkg for field widths.
`default_nettype none
interface aba_req_if import aba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SIZE_W-1:0]    request_size;
  logic [ALIGN_W-1:0]   request_align;

  modport source (output valid, request_size, request_align, input ready);
  modport sink   (input valid, request_size, request_align, output ready);
endinterface

interface aba_res_if import aba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [USED_W-1:0]    grant_offset;
  logic [SIZE_W-1:0]    grant_size;
  logic [ALIGN_W-1:0]   grant_align;
  logic [GEN_W-1:0]     grant_generation;

  modport source (output valid, status, grant_offset, grant_size, grant_align,
                  grant_generation, input ready);
  modport sink   (input valid, status, grant_offset, grant_size, grant_align,
                  grant_generation, output ready);
endinterface
`default_nettype wire

/* design/aba_div.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on aba_pkg for widths.
`default_nettype none
module aba_div import aba_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [USED_W-1:0]  dividend,
  input  wire logic [ALIGN_W-1:0] divisor,
  output logic                    done,
  output logic [ALIGN_W-1:0]      rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [USED_W-1:0]    shreg;
  logic [ALIGN_W:0]     trial;
  logic [ALIGN_W:0]     diff;
  logic [ALIGN_W-1:0]   rem_next;

  always_comb begin
    trial = {rem, shreg[USED_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[ALIGN_W-1:0];
    end else begin
      rem_next = trial[ALIGN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= {shreg[USED_W-2:0], 1'b0};
        cnt   <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(USED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor once a step has run
  assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < divisor))
    else $error("remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("divider did not stop after done");

  assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |=> (cnt == $past(cnt) + DIV_CNT_W'(1)) || done)
    else $error("divider step count skipped");

endmodule
`default_nettype wire

/* design/aligned_bump_allocator.sv */
// Aligned bump allocator: an accepted request runs a bit-serial remainder pass, a
// hand-over of the remainder, a pad/offset add, an end check and a load of the
// output word; invalid pool, empty size and zero alignment go from accept straight
// to the load of the output word (S_FIN), which waits while the output is held. One
// request at a time: the next word is taken only once the last result is loaded; the
// output register lets it start while a result waits. Sync reset zeroes used, cap and gen.
`default_nettype none
module aligned_bump_allocator import aba_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  aba_req_if.sink                   req,
  aba_res_if.source                 res
);

  state_t             state;
  logic [CAP_W-1:0]   capacity_bytes;
  logic [GEN_W-1:0]   pool_generation;
  logic [USED_W-1:0]  used_bytes;

  logic [SIZE_W-1:0]  req_size;
  logic [ALIGN_W-1:0] req_align;
  logic [SUM_W-1:0]   offset;
  status_t            pend_status;
  logic [SUM_W-1:0]   pend_end;

  logic               div_start;
  logic               div_done;
  logic [ALIGN_W-1:0] div_rem;

  logic               in_accept;
  logic               out_load;
  logic [ALIGN_W-1:0] pad;
  logic [SUM_W-1:0]   end_sum;

  logic               out_valid;
  status_t            out_status;
  logic [USED_W-1:0]  out_offset;
  logic [SIZE_W-1:0]  out_size;
  logic [ALIGN_W-1:0] out_align;
  logic [GEN_W-1:0]   out_gen;

  aba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (used_bytes),
    .divisor  (req_align),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign req.ready = (state == S_IDLE);
  assign in_accept = req.valid && req.ready;
  assign out_load  = (state == S_FIN) && (!out_valid || res.ready);
  assign div_start = in_accept && (pool_generation != '0) && (used_bytes <= capacity_bytes)
                     && (req.request_size != '0) && (req.request_align != '0);

  assign pad     = (div_rem == '0) ? '0 : req_align - div_rem;
  assign end_sum = offset + SUM_W'(req_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      capacity_bytes  <= '0;
      pool_generation <= '0;
      used_bytes      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY:   capacity_bytes  <= cfg_wdata[CAP_W-1:0];
          CFG_GENERATION: pool_generation <= cfg_wdata[GEN_W-1:0];
          default: ;
        endcase
      end

      // a new word may replace the one taken in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_size  <= req.request_size;
            req_align <= req.request_align;
            if (pool_generation == '0 || used_bytes > capacity_bytes) begin
              pend_status <= ST_INVALID;
              state       <= S_FIN;
            end else if (req.request_size == '0) begin
              pend_status <= ST_EMPTY;
              state       <= S_FIN;
            end else if (req.request_align == '0) begin
              pend_status <= ST_BAD_ALIGN;
              state       <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) state <= S_ADD;
        end
        S_ADD: begin
          offset <= SUM_W'(used_bytes) + SUM_W'(pad);
          state  <= S_CHK;
        end
        S_CHK: begin
          pend_end <= end_sum;
          if (offset > OFFSET_MAX || end_sum > OFFSET_MAX) begin
            pend_status <= ST_OVERFLOW;
          end else if (end_sum > SUM_W'(capacity_bytes)) begin
            pend_status <= ST_CAPACITY;
          end else begin
            pend_status <= ST_OK;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            if (pend_status == ST_OK) used_bytes <= pend_end[USED_W-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word register, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= pend_status;
      if (pend_status == ST_OK) begin
        out_offset <= offset[USED_W-1:0];
        out_size   <= req_size;
        out_align  <= req_align;
        out_gen    <= pool_generation;
      end else begin
        out_offset <= '0;
        out_size   <= '0;
        out_align  <= '0;
        out_gen    <= '0;
      end
    end
  end

  assign res.valid            = out_valid;
  assign res.status           = out_status;
  assign res.grant_offset     = out_offset;
  assign res.grant_size       = out_size;
  assign res.grant_align      = out_align;
  assign res.grant_generation = out_gen;

  assert property (@(posedge clk) disable iff (rst)
    !$stable(used_bytes) |-> $past(out_load && pend_status == ST_OK))
    else $error("used bytes moved without a granted word");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("remainder finished outside the divide step");

  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_OK) |->
      (res.grant_offset == '0 && res.grant_size == '0 && res.grant_generation == '0))
    else $error("error word carries a nonzero grant");

  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_OK) |-> (res.grant_align != '0 && res.grant_size != '0))
    else $error("granted word with zero size or alignment");

endmodule
`default_nettype wire

/* sim/tb_aligned_bump_allocator.sv */
// Self-checking testbench for aligned_bump_allocator: random and directed allocation
// words, a bit-accurate allocation predictor and a result checker.
// Depends on aba_pkg and the aba_req_if / aba_res_if interfaces of the design.
`timescale 1ns / 100ps
module tb_aligned_bump_allocator;
  import aba_pkg::*;

  localparam longint unsigned ADDR_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int DRAIN_CYCLES = 60;    // a margin beyond the request latency
  localparam int STALL_CYCLES = 400;

  typedef struct {
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
  } alloc_req_t;

  typedef struct {
    status_t            status;
    logic [USED_W-1:0]  offset;
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
    logic [GEN_W-1:0]   generation;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  aba_req_if req_ch ();
  aba_res_if res_ch ();

  aligned_bump_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pool model
  logic [CAP_W-1:0]  cap_model  = '0;
  logic [GEN_W-1:0]  gen_model  = '0;
  logic [USED_W-1:0] used_model = '0;

  alloc_req_t  pending_reqs[$];
  grant_t      expected_grants[$];
  alloc_req_t  nxt_req;
  grant_t      want;
  int unsigned n_issued = 0;
  int unsigned n_accepted = 0;
  int          fail_cnt = 0;

  logic        src_burst = 1'b0;
  logic        sink_burst = 1'b0;
  logic        stall_req = 1'b0;
  logic        stall_done = 1'b0;
  int unsigned stall_cnt = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;

  // Checks pool, size and alignment, rounds the pointer up to the alignment, range-checks, and advances on success.
  function automatic grant_t predict_alloc(input logic [SIZE_W-1:0] size,
                                           input logic [ALIGN_W-1:0] align);
    longint unsigned rem, pad, offs, fin;
    grant_t g;
    g = '{ST_OK, '0, '0, '0, '0};
    offs = 0;
    fin = 0;
    if (gen_model == '0 || used_model > cap_model) begin
      g.status = ST_INVALID;
    end else if (size == '0) begin
      g.status = ST_EMPTY;
    end else if (align == '0) begin
      g.status = ST_BAD_ALIGN;
    end else begin
      rem  = 64'(used_model) % 64'(align);
      pad  = (rem == 0) ? 64'd0 : 64'(align) - rem;
      offs = 64'(used_model) + pad;
      fin  = offs + 64'(size);
      if (offs > ADDR_LIMIT || fin > ADDR_LIMIT) g.status = ST_OVERFLOW;
      else if (fin > 64'(cap_model)) g.status = ST_CAPACITY;
    end
    if (g.status == ST_OK) begin
      g.offset     = offs[USED_W-1:0];
      g.size       = size;
      g.align      = align;
      g.generation = gen_model;
      used_model   = fin[USED_W-1:0];
    end
    return g;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_req(input logic [SIZE_W-1:0] size, input logic [ALIGN_W-1:0] align);
    pending_reqs.push_back('{size, align});
    n_issued++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_CAPACITY) cap_model = data[CAP_W-1:0];
    else gen_model = data[GEN_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_issued || expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_grants.push_back(predict_alloc(req_ch.request_size, req_ch.request_align));
        n_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt_req = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.request_size <= nxt_req.size;
          req_ch.request_align <= nxt_req.align;
          src_gap <= src_burst ? 0 : pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_grants.size() == 0) begin
          $error("result word with no request outstanding: status %0d", res_ch.status);
          fail_cnt++;
        end else begin
          want = expected_grants.pop_front();
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_ch.status);
            fail_cnt++;
          end
          if (res_ch.grant_offset !== want.offset) begin
            $error("grant_offset: expected %0h, got %0h", want.offset, res_ch.grant_offset);
            fail_cnt++;
          end
          if (res_ch.grant_size !== want.size) begin
            $error("grant_size: expected %0h, got %0h", want.size, res_ch.grant_size);
            fail_cnt++;
          end
          if (res_ch.grant_align !== want.align) begin
            $error("grant_align: expected %0h, got %0h", want.align, res_ch.grant_align);
            fail_cnt++;
          end
          if (res_ch.grant_generation !== want.generation) begin
            $error("grant_generation: expected %0h, got %0h", want.generation,
                   res_ch.grant_generation);
            fail_cnt++;
          end
        end
      end
      if (stall_req && !stall_done) begin
        // long hold-off so the block backs up onto its input
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt + 1 >= STALL_CYCLES) stall_done <= 1'b1;
        res_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (res_ch.valid && res_ch.ready && !sink_burst && $urandom_range(0, 1) == 1) begin
        sink_gap <= pick_gap();
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #16_000_000;
    $display("tb_aligned_bump_allocator: FAIL");
    $finish;
  end

  initial begin
    int unsigned n_items, r, lim, k;
    longint unsigned span, sz_max, sz, top;
    logic [GEN_W-1:0] gen_val;
    logic [ALIGN_W-1:0] al;

    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.request_size = '0;
    req_ch.request_align = '0;
    res_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // after reset the generation is zero: pool invalid
    queue_req(16, 8);
    wait_drained();
    // zero capacity
    cfg_write(CFG_GENERATION, 1);
    queue_req(1, 1);
    queue_req(0, 0);
    wait_drained();

    cfg_write(CFG_CAPACITY, 1000);
    queue_req(0, 4);
    queue_req(12, 0);
    queue_req(10, 1);
    queue_req(5, 7);              // non power of two pad
    queue_req(3, 3);
    queue_req(1, 16'hFFFF);
    queue_req(1, 1000);
    queue_req(976, 1);            // ends exactly at capacity
    queue_req(1, 1);
    queue_req('1, 1);             // end past offset width
    queue_req('1, 0);
    wait_drained();

    // capacity dropped below the pointer
    cfg_write(CFG_CAPACITY, 500);
    queue_req(8, 8);
    queue_req(0, 0);
    wait_drained();

    cfg_write(CFG_CAPACITY, 4096);
    cfg_write(CFG_GENERATION, 32'hFFFF_FFFF);
    queue_req(100, 256);
    wait_drained();

    for (int ph = 0; ph < 15; ph++) begin
      r = $urandom_range(0, 9);
      if (r < 3) span = 64'($urandom_range(64, 4096));
      else if (r < 6) span = 64'($urandom_range(4096, 1 << 20));
      else if (r < 9) span = 64'($urandom_range(1 << 20, 1 << 30));
      else span = 64'($urandom_range(1, 15)) << 32;
      sz_max = span / 20 + 1;
      lim = (span / 16 >= 65535) ? 65535 : int'(span / 16) + 1;

      gen_val = $urandom();
      if (gen_val == '0) gen_val = 1;
      if (ph % 7 == 5) gen_val = '0;
      top = 64'(used_model) + span;
      if (top > ADDR_LIMIT) top = ADDR_LIMIT;
      if (ph % 5 == 4) top = 64'(used_model) - 64'($urandom_range(1, 64));
      cfg_write(CFG_CAPACITY, CFG_W'(top));
      cfg_write(CFG_GENERATION, CFG_W'(gen_val));

      if (ph == 2) begin
        stall_req = 1'b1;
        src_burst = 1'b1;
      end
      if (ph == 6) begin
        src_burst = 1'b1;
        sink_burst = 1'b1;
      end

      n_items = (ph % 7 == 5 || ph % 5 == 4) ? 20 : 100;
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          k = $urandom_range(0, 15);
          while ((1 << k) > lim) k--;
          al = ALIGN_W'(1 << k);
        end else if (r < 85) begin
          al = ALIGN_W'($urandom_range(1, lim));
        end else begin
          al = ALIGN_W'($urandom_range(1, 65535));
        end
        sz = 1 + ({$urandom(), $urandom()} % sz_max);
        r = $urandom_range(0, 99);
        if (r >= 95) begin
          al = '0;
        end else if (r >= 90) begin
          sz = 0;
        end else if (r >= 82) begin
          sz = {$urandom(), $urandom()};
          al = ALIGN_W'($urandom());
        end
        queue_req(SIZE_W'(sz), al);
      end
      wait_drained();
      src_burst = 1'b0;
      sink_burst = 1'b0;
    end

    // top of the offset range
    cfg_write(CFG_CAPACITY, CFG_W'(ADDR_LIMIT));
    cfg_write(CFG_GENERATION, 32'hFFFF_FFFF);
    queue_req(SIZE_W'(ADDR_LIMIT - 64'(used_model) - 100), 1);
    queue_req(1, 16'hFFFF);       // pad runs past the offset width
    queue_req(100, 1);
    queue_req(1, 1);
    queue_req(0, 1);
    wait_drained();
    cfg_write(CFG_CAPACITY, 0);
    queue_req(1, 1);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("tb_aligned_bump_allocator: PASS");
    end else begin
      $display("tb_aligned_bump_allocator: FAIL");
    end
    $finish;
  end

endmodule
